>>> sv/clipped_box_row_masks_macros.svh
// assertion macros for the rtl datapath
// depends on nothing; included by the datapath
`ifndef CLIPPED_BOX_ROW_MASKS_MACROS_SVH
`define CLIPPED_BOX_ROW_MASKS_MACROS_SVH

// same-cycle implication, disabled in reset
`define CBRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cbrm_pkg.sv
// shared types and constants for the clipped box row mask block
// no dependencies
package cbrm_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int COORD_W   = 11;
    localparam int CALC_W    = COORD_W + 2;
    localparam int ROW_W     = 6;
    localparam int HALF_W    = 64;
    localparam int MASK_W    = 2 * HALF_W;
    localparam int COL_W     = $clog2(MASK_W) + 1;
    localparam int S_FIELD_W = 4 * COORD_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = ROW_W + MASK_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MASK = 3'b010,
        ST_EMIT = 3'b100
    } cbrm_state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
    } cbrm_cmd_t;

    typedef struct packed {
        logic empty;
        logic out_free;
        logic last;
    } cbrm_status_t;

endpackage

>>> sv/cbrm_ctrl.sv
// controller state machine: accept, mask setup, row emission
// depends on cbrm_pkg
module cbrm_ctrl
    import cbrm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  cbrm_status_t status,
    output cbrm_cmd_t    cmd
);

    cbrm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK: begin
                cmd.calc   = 1'b1;
                state_next = status.empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/cbrm_datapath.sv
// datapath: clipping, span and side masks, row counter, output register
// depends on cbrm_pkg and clipped_box_row_masks_macros.svh
`include "clipped_box_row_masks_macros.svh"
module cbrm_datapath
    import cbrm_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  cbrm_cmd_t            cmd,
    output cbrm_status_t         status
);

    localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int WW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int HW = $clog2(SCREEN_HEIGHT + 1);
    localparam logic signed [CALC_W-1:0] SW_S = CALC_W'(SCREEN_WIDTH);
    localparam logic signed [CALC_W-1:0] SH_S = CALC_W'(SCREEN_HEIGHT);

    logic signed [CALC_W-1:0] xs, ys, ws, hs, w1, h1, w2, h2, x2, y2;
    logic                     empty_next;

    logic [XW-1:0]     x0_reg;
    logic [WW-1:0]     w_reg;
    logic [YW-1:0]     y0_reg;
    logic [HW-1:0]     h_reg;
    logic              fill_reg;
    logic              empty_reg;
    logic [MASK_W-1:0] span_reg, span_next;
    logic [MASK_W-1:0] side_reg, side_next;
    logic [HW-1:0]     r_reg;
    logic              m_valid_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              m_last_reg;
    logic              last_row;
    logic              full_row;

    // clip right and bottom, then left and top
    always_comb begin
        xs = CALC_W'($signed(s_tdata[COORD_W-1:0]));
        ys = CALC_W'($signed(s_tdata[2*COORD_W-1:COORD_W]));
        ws = CALC_W'($signed(s_tdata[3*COORD_W-1:2*COORD_W]));
        hs = CALC_W'($signed(s_tdata[4*COORD_W-1:3*COORD_W]));
        w1 = (xs + ws > SW_S) ? SW_S - xs : ws;
        h1 = (ys + hs > SH_S) ? SH_S - ys : hs;
        w2 = (xs < 0) ? w1 + xs : w1;
        h2 = (ys < 0) ? h1 + ys : h1;
        x2 = (xs < 0) ? '0 : xs;
        y2 = (ys < 0) ? '0 : ys;
        empty_next = (w2 <= 0) || (h2 <= 0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg    <= x2[XW-1:0];
            w_reg     <= w2[WW-1:0];
            y0_reg    <= y2[YW-1:0];
            h_reg     <= h2[HW-1:0];
            fill_reg  <= s_tuser;
            empty_reg <= empty_next;
        end
    end

    // span covers the clipped columns, side only its leftmost and rightmost columns
    always_comb begin
        logic [COL_W-1:0] col_lo;
        logic [COL_W-1:0] col_end;
        col_lo  = COL_W'(x0_reg);
        col_end = COL_W'(x0_reg) + COL_W'(w_reg);
        for (int c = 0; c < MASK_W; c++) begin
            span_next[c] = (COL_W'(c) >= col_lo) && (COL_W'(c) < col_end);
            side_next[c] = (COL_W'(c) == col_lo) || (COL_W'(c) == col_end - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            span_reg <= span_next;
            side_reg <= side_next;
        end
    end

    assign last_row = (r_reg + 1'b1) == h_reg;
    assign full_row = fill_reg || (r_reg == '0) || last_row;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            r_reg <= '0;
        end else if (cmd.emit) begin
            r_reg <= r_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            row_reg    <= ROW_W'(y0_reg) + ROW_W'(r_reg);
            mask_reg   <= full_row ? span_reg : side_reg;
            m_last_reg <= last_row;
        end
    end

    assign status.empty    = empty_reg;
    assign status.out_free = !m_valid_reg || m_tready;
    assign status.last     = last_row;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}}, mask_reg, row_reg};

    `CBRM_ASSERT_NOW(a_emit_in_range, aclk, aresetn, cmd.emit, r_reg < h_reg,
        "row counter ran past clipped height")
    `CBRM_ASSERT_NEXT(a_last_reaches_out, aclk, aresetn, cmd.emit && last_row,
        m_valid_reg && m_last_reg, "last row did not reach output register")
    `CBRM_ASSERT_NOW(a_row_on_screen, aclk, aresetn, m_valid_reg,
        {1'b0, row_reg} < (ROW_W + 1)'(SCREEN_HEIGHT), "row index off screen")
    `CBRM_ASSERT_NEXT(a_span_edges, aclk, aresetn, cmd.calc && !empty_reg,
        span_reg[x0_reg] && side_reg[x0_reg], "span misses left edge column")

endmodule

>>> sv/clipped_box_row_masks.sv
// top level of the clipped box row mask block
// depends on cbrm_pkg, cbrm_ctrl, cbrm_datapath
//
// channel  dir  ports                          contents
// s_       in   s_tvalid s_tready s_tdata      origin_x origin_y box_width box_height
//                s_tuser                       fill_mode
// m_       out  m_tvalid m_tready m_tdata      row_index mask_low mask_high
//                m_tlast                       last_row
//
// a box is accepted and clipped in ST_IDLE, its column masks are built in ST_MASK,
// then rows go out one per cycle from a row counter while the output does not stall
// a box clipped to nothing goes from ST_MASK back to ST_IDLE and gives no item
// m_tready low while the output register is valid holds that register and the row counter
// reset clears the state machine and the output valid
module clipped_box_row_masks
    import cbrm_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x, origin_y, box_width, box_height, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // fill_mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_index, mask_low, mask_high, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    cbrm_cmd_t    cmd;
    cbrm_status_t status;

    cbrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbrm_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

>>> test/clipped_box_row_masks_tb.sv
`timescale 1ns / 100ps
// self-checking bench for clipped_box_row_masks: a table of directed boxes, then random boxes
// each accepted box is turned into its expected row masks, compared item by item on m_
// depends on cbrm_pkg and the clipped_box_row_masks rtl
module clipped_box_row_masks_tb;
    import cbrm_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = SCREEN_HEIGHT_DEF + 8;
    localparam int RANDOM_BOXES = 145;
    localparam logic [HALF_W-1:0] ALL_SET = {HALF_W{1'b1}};
    localparam logic [HALF_W-1:0] TOP_COL = {1'b1, {(HALF_W-1){1'b0}}};

    typedef struct packed {
        logic                      fill;
        logic signed [COORD_W-1:0] h;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } box_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic              last;
    } row_mask_t;

    // known: rows are typed in, all with the same mask
    typedef struct {
        box_t              b;
        bit                known;
        int                n;
        int                top;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
    } box_case_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    bit                known_en  = 1'b0;
    int                known_n   = 0;
    int                known_top = 0;
    logic [HALF_W-1:0] known_lo  = '0;
    logic [HALF_W-1:0] known_hi  = '0;

    row_mask_t rows_due[$];
    box_case_t box_cases[$];
    int tx_idle      = 0;
    int rx_idle      = 0;
    int errors       = 0;
    int boxes_sent   = 0;
    int empty_boxes  = 0;
    int rows_checked = 0;
    int quiet        = 0;

    clipped_box_row_masks u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    function automatic box_case_t box_case(input int x, input int y, input int w, input int h,
                                           input bit fill, input bit known, input int n,
                                           input int top, input logic [HALF_W-1:0] lo,
                                           input logic [HALF_W-1:0] hi);
        box_case_t bc;
        bc.b.x   = x[COORD_W-1:0];
        bc.b.y   = y[COORD_W-1:0];
        bc.b.w   = w[COORD_W-1:0];
        bc.b.h   = h[COORD_W-1:0];
        bc.b.fill = fill;
        bc.known = known;
        bc.n     = n;
        bc.top   = top;
        bc.lo    = lo;
        bc.hi    = hi;
        return bc;
    endfunction

    function automatic box_t rand_box();
        box_t        b;
        logic [63:0] raw;
        if ($urandom_range(99) < 12) begin
            raw = {$urandom, $urandom};
            b = raw[$bits(box_t)-1:0];
        end else begin
            b.x = COORD_W'($urandom_range(200) - 40);
            b.w = COORD_W'($urandom_range(150) - 6);
            b.y = COORD_W'($urandom_range(90) - 15);
            if ($urandom_range(9) < 7)
                b.h = COORD_W'($urandom_range(14) - 2);
            else
                b.h = COORD_W'($urandom_range(80) - 8);
        end
        b.fill = 1'($urandom_range(1));
        return b;
    endfunction

    // clip right and bottom first, then left and top; outline sits on the clipped box
    function automatic void queue_rows(input box_t b);
        int x, y, w, h, c, r;
        logic [MASK_W-1:0] span, side;
        row_mask_t e;
        x = b.x;
        y = b.y;
        w = b.w;
        h = b.h;
        if (x + w > SCREEN_WIDTH_DEF)
            w = SCREEN_WIDTH_DEF - x;
        if (y + h > SCREEN_HEIGHT_DEF)
            h = SCREEN_HEIGHT_DEF - y;
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (w <= 0 || h <= 0) begin
            empty_boxes++;
            return;
        end
        span = '0;
        side = '0;
        for (c = x; c < x + w; c++)
            span[c] = 1'b1;
        side[x]         = 1'b1;
        side[x + w - 1] = 1'b1;
        for (r = 0; r < h; r++) begin
            e.row = ROW_W'(y + r);
            {e.hi, e.lo} = (b.fill || r == 0 || r == h - 1) ? span : side;
            e.last = (r == h - 1);
            rows_due.push_back(e);
        end
    endfunction

    function automatic void check_field(input string name, input logic [HALF_W-1:0] want,
                                        input logic [HALF_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        row_mask_t got, want;
        box_t      seen;
        int        r;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                boxes_sent++;
                if (known_en) begin
                    if (known_n == 0)
                        empty_boxes++;
                    for (r = 0; r < known_n; r++) begin
                        want.row  = ROW_W'(known_top + r);
                        want.lo   = known_lo;
                        want.hi   = known_hi;
                        want.last = (r == known_n - 1);
                        rows_due.push_back(want);
                    end
                end else begin
                    seen = {s_tuser, s_tdata[S_FIELD_W-1:0]};
                    queue_rows(seen);
                end
            end
            if (m_tvalid && m_tready) begin
                got.row  = m_tdata[ROW_W-1:0];
                got.lo   = m_tdata[ROW_W +: HALF_W];
                got.hi   = m_tdata[ROW_W+HALF_W +: HALF_W];
                got.last = m_tlast;
                rows_checked++;
                if (rows_due.size() == 0) begin
                    errors++;
                    $display("%0t: extra item, expected none actual row %0d lo %h hi %h last %0b",
                             $time, got.row, got.lo, got.hi, got.last);
                end else begin
                    want = rows_due.pop_front();
                    check_field("row_index", HALF_W'(want.row), HALF_W'(got.row));
                    check_field("mask_low", want.lo, got.lo);
                    check_field("mask_high", want.hi, got.hi);
                    check_field("last_row", HALF_W'(want.last), HALF_W'(got.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d rows still due",
                     $time, QUIET_LIMIT, rows_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_box(input box_case_t bc);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(S_TDATA_W-S_FIELD_W){1'b0}}, bc.b.h, bc.b.w, bc.b.y, bc.b.x};
        s_tuser   <= bc.b.fill;
        known_en  <= bc.known;
        known_n   <= bc.n;
        known_top <= bc.top;
        known_lo  <= bc.lo;
        known_hi  <= bc.hi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_rows_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rows_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        box_case_t bc;
        int ph, k;
        // full screen fill, then outline
        box_cases.push_back(box_case(0, 0, 128, 64, 1, 1, 64, 0, ALL_SET, ALL_SET));
        box_cases.push_back(box_case(0, 0, 128, 64, 0, 0, 0, 0, '0, '0));
        // field extremes
        box_cases.push_back(box_case(-1024, -1024, 1023, 1023, 1, 1, 0, 0, '0, '0));
        box_cases.push_back(box_case(-100, -100, 1023, 1023, 1, 1, 64, 0, ALL_SET, ALL_SET));
        box_cases.push_back(box_case(1023, 1023, 1023, 1023, 0, 1, 0, 0, '0, '0));
        box_cases.push_back(box_case(0, 0, -1024, -1024, 0, 1, 0, 0, '0, '0));
        // zero width or height
        box_cases.push_back(box_case(0, 0, 0, 10, 1, 1, 0, 0, '0, '0));
        box_cases.push_back(box_case(0, 0, 10, 0, 1, 1, 0, 0, '0, '0));
        // thin boxes
        box_cases.push_back(box_case(5, 7, 1, 1, 0, 1, 1, 7, 64'h20, '0));
        box_cases.push_back(box_case(10, 20, 30, 1, 0, 1, 1, 20, 64'h0000_00FF_FFFF_FC00, '0));
        box_cases.push_back(box_case(127, 0, 1, 64, 0, 1, 64, 0, '0, TOP_COL));
        box_cases.push_back(box_case(0, 62, 128, 5, 0, 1, 2, 62, ALL_SET, ALL_SET));
        box_cases.push_back(box_case(0, 63, 128, 1, 1, 1, 1, 63, ALL_SET, ALL_SET));
        box_cases.push_back(box_case(127, 63, 1, 1, 1, 1, 1, 63, '0, TOP_COL));
        // clipped on each side, outline drawn on the clip edge, and boxes clipped to nothing
        box_cases.push_back(box_case(-5, 10, 20, 10, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(3, -3, 10, 8, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(120, 60, 100, 100, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(0, -1, 128, 66, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(-20, 0, 20, 5, 1, 1, 0, 0, '0, '0));
        box_cases.push_back(box_case(0, -10, 5, 10, 1, 1, 0, 0, '0, '0));
        // at and across the half boundary
        box_cases.push_back(box_case(60, 30, 8, 4, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(64, 0, 64, 3, 0, 0, 0, 0, '0, '0));
        box_cases.push_back(box_case(63, 40, 2, 6, 1, 0, 0, 0, '0, '0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 36;
        rx_idle = 50;
        foreach (box_cases[i])
            send_box(box_cases[i]);
        wait_rows_done();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 36 : (ph == 1) ? 50 : 0;
            rx_idle = (ph == 0) ? 50 : (ph == 1) ? 36 : 0;
            for (k = 0; k < RANDOM_BOXES; k++) begin
                if (ph == 1 && k == RANDOM_BOXES / 2)
                    wait_rows_done();
                bc = box_case(0, 0, 0, 0, 0, 0, 0, 0, '0, '0);
                bc.b = rand_box();
                send_box(bc);
            end
        end

        s_tvalid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d boxes sent (%0d clipped to nothing), %0d row items checked",
                 boxes_sent, empty_boxes, rows_checked);
        $display("sender and receiver stalled in turn, then both ran back to back");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
